FILE: design/lbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the largest blob centroid unit.
// No dependencies.
package lbc_pkg;

    localparam int PIXEL_W      = 8;
    localparam int COUNT_OUT_W  = 19;
    localparam int ROW_OUT_W    = 13;
    localparam int COL_OUT_W    = 14;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int COLS_CFG_W   = 10;
    localparam int ROWS_CFG_W   = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 10'd640;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 9'd480;

endpackage

FILE: design/largest_blob_centroid_unit.sv
`timescale 1ns / 1ps
// Largest 4-connected blob of a binary mask and its centroid, top level.
// Depends on lbc_pkg and lbc_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | sink      | in_valid / in_stall     | pixel_value
//  out     | source    | out_valid / out_stall   | largest_count, centroid_row_q4,
//          |           |                         | centroid_col_q4, label_overflow
//  cfg     | sink      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Per pixel: a background pixel goes straight from idle to commit. A foreground
// pixel reads its up neighbor, follows a valid one to its root in the label
// table, decides, updates the table (a merge first relinks the dropped root
// and reads its sums) and commits; the single-port-read table serialises this.
// Frame end: a root scan over labels 1 to next_label, then bit-serial division
// of the row sum and then the column sum, then the load of the output register.
// Reset clears control state only; the memories hold no reset value.
// A stalled result waits in the output register while the next frame's
// pixels are already taken.
module largest_blob_centroid_unit
    import lbc_pkg::*;
#(
    parameter int MAX_COLS   = 640,
    parameter int MAX_ROWS   = 480,
    parameter int MAX_LABELS = 512,
    parameter int FRAC_BITS  = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIXEL_W-1:0]     pixel_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_OUT_W-1:0] largest_count,
    output logic [ROW_OUT_W-1:0]   centroid_row_q4,
    output logic [COL_OUT_W-1:0]   centroid_col_q4,
    output logic                   label_overflow,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CPW = $clog2(MAX_COLS);
    localparam int RPW = $clog2(MAX_ROWS);
    localparam int LW  = $clog2(MAX_LABELS);
    localparam int CW  = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam longint unsigned RS_MAX = longint'(MAX_COLS) * MAX_ROWS * MAX_ROWS;
    localparam longint unsigned CS_MAX = longint'(MAX_COLS) * MAX_COLS * MAX_ROWS;
    localparam int RSW = $clog2(RS_MAX);
    localparam int CSW = $clog2(CS_MAX);
    localparam int NW  = ((RSW > CSW) ? RSW : CSW) + FRAC_BITS;
    localparam int DCW = $clog2(NW);

    typedef struct packed {
        logic [LW-1:0]  parent;
        logic [CW-1:0]  cnt;
        logic [RSW-1:0] rsum;
        logic [CSW-1:0] csum;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_WALK,
        S_DECIDE,
        S_ONE,
        S_GONE,
        S_KEEP,
        S_COMMIT,
        S_SCAN,
        S_SCAN_LAST,
        S_DIV_LOAD,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [31:0]           cols_eff;
    logic [31:0]           rows_eff;

    // frame state
    logic [CPW-1:0] col_pos_reg;
    logic [RPW-1:0] row_pos_reg;
    logic [LW-1:0]  next_label_reg;
    logic [LW-1:0]  left_label_reg;
    logic           overflow_reg;

    // per-pixel working registers
    logic [CPW-1:0] cur_col_reg;
    logic [RPW-1:0] cur_row_reg;
    logic [LW-1:0]  up_reg;
    logic [LW-1:0]  walk_reg;
    logic [LW-1:0]  lab_reg;
    logic [LW-1:0]  keep_reg;
    logic [LW-1:0]  gone_reg;
    logic [CW-1:0]  g_cnt_reg;
    logic [RSW-1:0] g_rs_reg;
    logic [CSW-1:0] g_cs_reg;

    // end-of-frame scan and division
    logic [LW-1:0]  scan_lab_reg;
    logic [LW-1:0]  pend_lab_reg;
    logic           pend_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic [RSW-1:0] best_rs_reg;
    logic [CSW-1:0] best_cs_reg;
    logic           div_sel_reg;
    logic [NW-1:0]  num_reg;
    logic [CW-1:0]  rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DCW-1:0] step_reg;
    logic [NW-1:0]  qrow_reg;

    // output register
    logic                   out_valid_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic [ROW_OUT_W-1:0]   row_out_reg;
    logic [COL_OUT_W-1:0]   col_out_reg;
    logic                   ovf_out_reg;

    // memories
    logic            ln_we;
    logic [LW-1:0]   ln_rdata;
    logic            tab_we;
    logic [LW-1:0]   tab_waddr;
    entry_t          tab_wdata;
    logic [LW-1:0]   tab_raddr;
    entry_t          tab_rdata;

    // combinational helpers
    logic           in_xfer;
    logic           up_ok;
    logic           walk_stop;
    logic [LW-1:0]  lf;
    logic [LW-1:0]  nz;
    logic           both_zero;
    logic           single;
    logic [LW-1:0]  keep_w;
    logic [LW-1:0]  gone_w;
    logic           new_ok;
    logic [LW-1:0]  new_lab;
    logic           row_end;
    logic           frame_end;
    logic           scan_better;
    logic [CW:0]    trial;
    logic           trial_ge;
    logic [NW-1:0]  quo_next;
    logic [63:0]    cnt_wide;
    logic [63:0]    qrow_wide;
    logic [63:0]    qcol_wide;

    assign cols_eff = (cols_cfg_reg == '0) ? 32'd1 :
                      ((32'(cols_cfg_reg) > MAX_COLS) ? 32'(MAX_COLS) : 32'(cols_cfg_reg));
    assign rows_eff = (rows_cfg_reg == '0) ? 32'd1 :
                      ((32'(rows_cfg_reg) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(rows_cfg_reg));

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // up neighbor counts only when opened in this frame
    assign up_ok = (cur_row_reg != '0) && (ln_rdata != '0) &&
                   (ln_rdata <= next_label_reg) && (32'(ln_rdata) < MAX_LABELS);
    assign walk_stop = (tab_rdata.parent == walk_reg) || (tab_rdata.parent == '0) ||
                       (32'(tab_rdata.parent) >= MAX_LABELS);

    // left label is always a root: nothing merges between two adjacent pixels
    assign lf        = (cur_col_reg != '0) ? left_label_reg : '0;
    assign nz        = (up_reg != '0) ? up_reg : lf;
    assign both_zero = (up_reg == '0) && (lf == '0);
    assign single    = (up_reg == '0) || (lf == '0) || (up_reg == lf);
    assign keep_w    = (up_reg < lf) ? up_reg : lf;
    assign gone_w    = (up_reg < lf) ? lf : up_reg;
    assign new_ok    = (32'(next_label_reg) + 32'd1) < MAX_LABELS;
    assign new_lab   = next_label_reg + LW'(1);

    assign row_end   = !((32'(col_pos_reg) + 32'd1) < cols_eff);
    assign frame_end = row_end && !((32'(row_pos_reg) + 32'd1) < rows_eff);

    assign scan_better = pend_reg && (tab_rdata.parent == pend_lab_reg) &&
                         (tab_rdata.cnt > best_cnt_reg);

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, num_reg[NW-1]};
    assign trial_ge = trial >= {1'b0, best_cnt_reg};
    assign quo_next = {quo_reg[NW-2:0], trial_ge};

    assign cnt_wide  = 64'(best_cnt_reg);
    assign qrow_wide = 64'(qrow_reg);
    assign qcol_wide = 64'(quo_reg);

    // table port control
    always_comb
    begin
        tab_raddr = '0;
        tab_we    = 1'b0;
        tab_waddr = lab_reg;
        tab_wdata = tab_rdata;
        unique case (state_reg)
            S_UP:
            begin
                tab_raddr = ln_rdata;
            end
            S_WALK:
            begin
                tab_raddr = tab_rdata.parent;
            end
            S_DECIDE:
            begin
                tab_raddr        = single ? nz : gone_w;
                tab_we           = both_zero && new_ok;
                tab_waddr        = new_lab;
                tab_wdata.parent = new_lab;
                tab_wdata.cnt    = CW'(1);
                tab_wdata.rsum   = RSW'(cur_row_reg);
                tab_wdata.csum   = CSW'(cur_col_reg);
            end
            S_ONE:
            begin
                tab_we         = 1'b1;
                tab_waddr      = lab_reg;
                tab_wdata.cnt  = tab_rdata.cnt + CW'(1);
                tab_wdata.rsum = tab_rdata.rsum + RSW'(cur_row_reg);
                tab_wdata.csum = tab_rdata.csum + CSW'(cur_col_reg);
            end
            S_GONE:
            begin
                tab_raddr        = keep_reg;
                tab_we           = 1'b1;
                tab_waddr        = gone_reg;
                tab_wdata.parent = keep_reg;
            end
            S_KEEP:
            begin
                tab_we         = 1'b1;
                tab_waddr      = keep_reg;
                tab_wdata.cnt  = tab_rdata.cnt + g_cnt_reg + CW'(1);
                tab_wdata.rsum = tab_rdata.rsum + g_rs_reg + RSW'(cur_row_reg);
                tab_wdata.csum = tab_rdata.csum + g_cs_reg + CSW'(cur_col_reg);
            end
            S_SCAN:
            begin
                tab_raddr = scan_lab_reg;
            end
            default:
            begin
                tab_raddr = '0;
            end
        endcase
    end

    assign ln_we = (state_reg == S_COMMIT);

    lbc_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (ln_we),
        .waddr (cur_col_reg),
        .wdata (lab_reg),
        .raddr (col_pos_reg),
        .rdata (ln_rdata)
    );

    lbc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_LABELS)
    ) u_label_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COLS_RESET;
            rows_cfg_reg <= ROWS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_COLS: cols_cfg_reg <= cfg_data[COLS_CFG_W-1:0];
                REG_FRAME_ROWS: rows_cfg_reg <= cfg_data[ROWS_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            next_label_reg <= '0;
            left_label_reg <= '0;
            overflow_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            div_sel_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cur_col_reg <= col_pos_reg;
                        cur_row_reg <= row_pos_reg;
                        lab_reg     <= '0;
                        state_reg   <= (pixel_value != '0) ? S_UP : S_COMMIT;
                    end
                end
                S_UP:
                begin
                    walk_reg  <= ln_rdata;
                    up_reg    <= '0;
                    state_reg <= up_ok ? S_WALK : S_DECIDE;
                end
                S_WALK:
                begin
                    if (walk_stop)
                    begin
                        up_reg    <= walk_reg;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        walk_reg <= tab_rdata.parent;
                    end
                end
                S_DECIDE:
                begin
                    if (both_zero)
                    begin
                        if (new_ok)
                        begin
                            next_label_reg <= new_lab;
                            lab_reg        <= new_lab;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        state_reg <= S_COMMIT;
                    end
                    else if (single)
                    begin
                        lab_reg   <= nz;
                        state_reg <= S_ONE;
                    end
                    else
                    begin
                        keep_reg  <= keep_w;
                        gone_reg  <= gone_w;
                        lab_reg   <= keep_w;
                        state_reg <= S_GONE;
                    end
                end
                S_ONE:
                begin
                    state_reg <= S_COMMIT;
                end
                S_GONE:
                begin
                    g_cnt_reg <= tab_rdata.cnt;
                    g_rs_reg  <= tab_rdata.rsum;
                    g_cs_reg  <= tab_rdata.csum;
                    state_reg <= S_KEEP;
                end
                S_KEEP:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (!row_end)
                    begin
                        left_label_reg <= lab_reg;
                        col_pos_reg    <= col_pos_reg + CPW'(1);
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        col_pos_reg    <= '0;
                        left_label_reg <= '0;
                        if (!frame_end)
                        begin
                            row_pos_reg <= row_pos_reg + RPW'(1);
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            row_pos_reg  <= '0;
                            scan_lab_reg <= LW'(1);
                            best_cnt_reg <= '0;
                            best_rs_reg  <= '0;
                            best_cs_reg  <= '0;
                            div_sel_reg  <= 1'b0;
                            pend_reg     <= 1'b0;
                            state_reg    <= (next_label_reg == '0) ? S_DIV_LOAD : S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_better)
                    begin
                        best_cnt_reg <= tab_rdata.cnt;
                        best_rs_reg  <= tab_rdata.rsum;
                        best_cs_reg  <= tab_rdata.csum;
                    end
                    pend_reg     <= 1'b1;
                    pend_lab_reg <= scan_lab_reg;
                    if (scan_lab_reg == next_label_reg)
                    begin
                        state_reg <= S_SCAN_LAST;
                    end
                    else
                    begin
                        scan_lab_reg <= scan_lab_reg + LW'(1);
                    end
                end
                S_SCAN_LAST:
                begin
                    if (scan_better)
                    begin
                        best_cnt_reg <= tab_rdata.cnt;
                        best_rs_reg  <= tab_rdata.rsum;
                        best_cs_reg  <= tab_rdata.csum;
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= S_DIV_LOAD;
                end
                S_DIV_LOAD:
                begin
                    num_reg   <= div_sel_reg ? (NW'(best_cs_reg) << FRAC_BITS)
                                             : (NW'(best_rs_reg) << FRAC_BITS);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= trial_ge ? CW'(trial - {1'b0, best_cnt_reg}) : CW'(trial);
                    num_reg  <= num_reg << 1;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + DCW'(1);
                    if (step_reg == DCW'(NW - 1))
                    begin
                        if (!div_sel_reg)
                        begin
                            qrow_reg    <= quo_next;
                            div_sel_reg <= 1'b1;
                            state_reg   <= S_DIV_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        count_out_reg  <= cnt_wide[COUNT_OUT_W-1:0];
                        if (best_cnt_reg == '0)
                        begin
                            row_out_reg <= '0;
                            col_out_reg <= '0;
                        end
                        else
                        begin
                            row_out_reg <= qrow_wide[ROW_OUT_W-1:0];
                            col_out_reg <= qcol_wide[COL_OUT_W-1:0];
                        end
                        ovf_out_reg    <= overflow_reg;
                        next_label_reg <= '0;
                        overflow_reg   <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // in S_OUT quo_reg holds the column quotient
    assign out_valid       = out_valid_reg;
    assign largest_count   = count_out_reg;
    assign centroid_row_q4 = row_out_reg;
    assign centroid_col_q4 = col_out_reg;
    assign label_overflow  = ovf_out_reg;

endmodule

FILE: design/lbc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual port RAM, one write port, one registered read port.
// No dependencies.
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/lbc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the largest blob centroid unit, with its bind.
// Depends on lbc_pkg and largest_blob_centroid_unit.
module lbc_checker
    import lbc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [COUNT_OUT_W-1:0] largest_count,
    input logic [ROW_OUT_W-1:0]   centroid_row_q4,
    input logic [COL_OUT_W-1:0]   centroid_col_q4,
    input logic                   label_overflow
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable({largest_count, centroid_row_q4, centroid_col_q4, label_overflow}))
        else $error("result payload changed while stalled");

    // the unit stalls its input in the cycle after every pixel transfer
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("pixel taken back to back");

    // a new result comes only out of the busy end-of-frame sequence
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without frame-end work");

    // an empty frame gives a zero centroid
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (largest_count == '0) |->
            (centroid_row_q4 == '0) && (centroid_col_q4 == '0))
        else $error("nonzero centroid for empty frame");

endmodule

bind largest_blob_centroid_unit lbc_checker u_lbc_checker (.*);

FILE: tb/tb_largest_blob_centroid_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of largest_blob_centroid_unit: drives mask frames,
// predicts the largest blob and its centroid per frame, checks every result.
// Depends on lbc_pkg and the design files.
module tb_largest_blob_centroid_unit;
    import lbc_pkg::*;

    localparam int MAX_COLS   = 640;
    localparam int MAX_ROWS   = 480;
    localparam int MAX_LABELS = 512;
    localparam int FRAC_BITS  = 4;
    localparam int DRAIN_CYCLES = 1200;   // root scan + division, worst case
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic [ROW_OUT_W-1:0]   row_q;
        logic [COL_OUT_W-1:0]   col_q;
        logic                   ovf;
    } blob_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     pixel_value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COUNT_OUT_W-1:0] largest_count;
    logic [ROW_OUT_W-1:0]   centroid_row_q4;
    logic [COL_OUT_W-1:0]   centroid_col_q4;
    logic                   label_overflow;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    largest_blob_centroid_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Labeling predictor: single-pass labels with a merge table.
    // ---------------------------------------------------------------
    int unsigned     line_labels [MAX_COLS];
    int unsigned     parent_of   [MAX_LABELS];
    longint unsigned blob_size   [MAX_LABELS];
    longint unsigned blob_rsum   [MAX_LABELS];
    longint unsigned blob_csum   [MAX_LABELS];
    int unsigned     labels_open, cur_row, cur_col, left_lab;
    bit              labels_ran_out;
    int unsigned     reg_cols = COLS_RESET, reg_rows = ROWS_RESET;

    blob_result_t    pending_blobs[$];
    int              errors = 0;
    int              pixels_sent = 0, frames_seen = 0, overflow_frames = 0;
    bit              idle_on = 1'b1;
    int              hold_cycles = 0;
    longint          cycles = 0;

    function automatic int unsigned root_of(int unsigned l);
        int unsigned p;
        if (l == 0 || l > labels_open || l >= MAX_LABELS)
            return 0;
        for (int i = 0; i < MAX_LABELS; i++)
        begin
            p = parent_of[l];
            if (p == l || p == 0 || p >= MAX_LABELS)
                break;
            l = p;
        end
        return l;
    endfunction

    function automatic void blob_track_pixel(logic [PIXEL_W-1:0] v);
        int unsigned cols, rows, col, row, lab, up, lf, keep, gone, best;
        longint unsigned best_n, rq, cq;
        blob_result_t r;
        cols = (reg_cols < 1) ? 1 : (reg_cols > MAX_COLS) ? MAX_COLS : reg_cols;
        rows = (reg_rows < 1) ? 1 : (reg_rows > MAX_ROWS) ? MAX_ROWS : reg_rows;
        col  = (cur_col < MAX_COLS) ? cur_col : MAX_COLS - 1;
        row  = cur_row;
        lab  = 0;
        if (v != 0)
        begin
            up = (row > 0) ? root_of(line_labels[col]) : 0;
            lf = (col > 0) ? root_of(left_lab) : 0;
            if (up == 0 && lf == 0)
            begin
                if (labels_open + 1 < MAX_LABELS)
                begin
                    labels_open++;
                    lab = labels_open;
                    parent_of[lab] = lab;
                    blob_size[lab] = 0;
                    blob_rsum[lab] = 0;
                    blob_csum[lab] = 0;
                end
                else
                    labels_ran_out = 1'b1;
            end
            else if (up == 0 || lf == 0 || up == lf)
                lab = (up != 0) ? up : lf;
            else
            begin
                keep = (up < lf) ? up : lf;
                gone = (up < lf) ? lf : up;
                parent_of[gone] = keep;
                blob_size[keep] += blob_size[gone];
                blob_rsum[keep] += blob_rsum[gone];
                blob_csum[keep] += blob_csum[gone];
                lab = keep;
            end
            if (lab != 0)
            begin
                blob_size[lab] += 1;
                blob_rsum[lab] += row;
                blob_csum[lab] += col;
            end
        end
        line_labels[col] = lab;
        left_lab = lab;
        if (cur_col + 1 < cols)
        begin
            cur_col++;
            return;
        end
        cur_col  = 0;
        left_lab = 0;
        if (cur_row + 1 < rows)
        begin
            cur_row++;
            return;
        end
        // frame done: pick largest root, smaller label wins ties
        best = 0;
        best_n = 0;
        r = '0;
        for (int unsigned l = 1; l <= labels_open && l < MAX_LABELS; l++)
            if (parent_of[l] == l && blob_size[l] > best_n)
            begin
                best_n = blob_size[l];
                best = l;
            end
        r.count = best_n[COUNT_OUT_W-1:0];
        if (best != 0 && best_n != 0)
        begin
            rq = (blob_rsum[best] << FRAC_BITS) / best_n;
            cq = (blob_csum[best] << FRAC_BITS) / best_n;
            r.row_q = rq[ROW_OUT_W-1:0];
            r.col_q = cq[COL_OUT_W-1:0];
        end
        r.ovf = labels_ran_out;
        pending_blobs.push_back(r);
        labels_open = 0;
        cur_row = 0;
        cur_col = 0;
        left_lab = 0;
        labels_ran_out = 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        blob_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_blobs.size() == 0)
            begin
                $error("result transfer with no frame pending");
                errors++;
            end
            else
            begin
                e = pending_blobs.pop_front();
                frames_seen++;
                if (e.ovf)
                    overflow_frames++;
                if (largest_count !== e.count)
                begin
                    $error("largest_count exp %0d got %0d", e.count, largest_count);
                    errors++;
                end
                if (centroid_row_q4 !== e.row_q)
                begin
                    $error("centroid_row_q4 exp %0d got %0d", e.row_q, centroid_row_q4);
                    errors++;
                end
                if (centroid_col_q4 !== e.col_q)
                begin
                    $error("centroid_col_q4 exp %0d got %0d", e.col_q, centroid_col_q4);
                    errors++;
                end
                if (label_overflow !== e.ovf)
                begin
                    $error("label_overflow exp %0d got %0d", e.ovf, label_overflow);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure: a long hold when asked, else random bursts while idle_on is set.
    always @(posedge clk)
    begin
        static int burst_left = 0;
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b1;
            burst_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            burst_left = $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL largest_blob_centroid_unit");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers; every task starts and ends just after a rising edge.
    // ---------------------------------------------------------------
    task automatic send_pixel(input logic [PIXEL_W-1:0] v);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        blob_track_pixel(v);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_blobs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_COLS)
            reg_cols = val[COLS_CFG_W-1:0];
        else if (idx == REG_FRAME_ROWS)
            reg_rows = val[ROWS_CFG_W-1:0];
    endtask

    task automatic set_frame(input int c, input int r);
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(c));
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(r));
    endtask

    function automatic logic [PIXEL_W-1:0] fg_value();
        return PIXEL_W'($urandom_range(1, 255));
    endfunction

    // Random frame of the current size; foreground clusters near foreground above or to the left.
    task automatic send_random_frame(input int density);
        int cols, rows;
        bit above [MAX_COLS];
        bit fg, left_fg;
        cols = (reg_cols < 1) ? 1 : (reg_cols > MAX_COLS) ? MAX_COLS : reg_cols;
        rows = (reg_rows < 1) ? 1 : (reg_rows > MAX_ROWS) ? MAX_ROWS : reg_rows;
        for (int r = 0; r < rows; r++)
        begin
            left_fg = 1'b0;
            for (int c = 0; c < cols; c++)
            begin
                fg = $urandom_range(0, 99) < ((above[c] || left_fg) ? density + 30
                                                                  : density);
                above[c] = fg;
                left_fg  = fg;
                send_pixel(fg ? fg_value() : 8'd0);
            end
        end
    endtask

    task automatic send_frame_bits(input string pattern);
        for (int i = 0; i < pattern.len(); i++)
            send_pixel(pattern[i] == "1" ? fg_value() : 8'd0);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_shapes();
        set_frame(3, 3);
        send_frame_bits("000000000");             // empty frame
        send_frame_bits("111111111");             // full frame
        send_frame_bits("101101111");             // U shape forces a merge
        send_pixel(8'd1); send_pixel(8'd128); send_pixel(8'd255);
        send_pixel(8'd0); send_pixel(8'd2);  send_pixel(8'd0);
        send_pixel(8'd64); send_pixel(8'd0); send_pixel(8'd127);
        set_frame(5, 1);
        send_frame_bits("11011");                 // tie goes to first blob
    endtask

    task automatic test_dimension_extremes();
        set_frame(1, 1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        set_frame(0, 0);                          // clamps to 1x1
        send_pixel(8'd7);
        set_frame(1023, 1);                       // clamps to full width
        send_random_frame(40);
    endtask

    task automatic test_label_overflow();
        // checkerboard dots, one label each, more than the table holds
        set_frame(40, 26);
        for (int r = 0; r < 26; r++)
            for (int c = 0; c < 40; c++)
                send_pixel(((r + c) % 2 == 0) ? fg_value() : 8'd0);
    endtask

    task automatic test_random_frames(input int n_items);
        int target;
        target = pixels_sent + n_items;
        while (pixels_sent < target)
        begin
            set_frame($urandom_range(1, 8), $urandom_range(1, 6));
            repeat ($urandom_range(1, 2))
                send_random_frame($urandom_range(0, 70));
        end
    endtask

    task automatic test_backpressure();
        set_frame(2, 2);
        hold_cycles = 400;                        // receiver blocks, sender keeps going
        repeat (10)
            send_random_frame(50);
        in_valid <= 1'b0;
        while (pending_blobs.size() != 0)         // sender waits for all results
            @(posedge clk);
        repeat (3)
            send_random_frame(50);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_shapes();
        test_dimension_extremes();
        test_label_overflow();
        test_backpressure();
        test_random_frames(60);
        idle_on = 1'b0;                           // closing stretch at full rate
        test_random_frames(50);

        wait_drained();
        if (pending_blobs.size() != 0)
        begin
            $error("%0d frame results never arrived", pending_blobs.size());
            errors++;
        end
        $display("Covered %0d pixels in %0d frames (%0d with label overflow),",
                 pixels_sent, frames_seen, overflow_frames);
        $display("sizes from 1x1 to the clamped maximum, with random stalls on both sides.");
        if (errors == 0)
            $display("PASS largest_blob_centroid_unit");
        else
            $display("FAIL largest_blob_centroid_unit");
        $finish;
    end

endmodule
